FILE: hdl/pcs_pkg.sv
// Shared constants for the pitch-class set canonical form block.
// Holds field widths and configuration register codes; depends on nothing.
package pcs_pkg;

  // Widths of the word fields on the ports.
  localparam int MASK_W  = 12;
  localparam int START_W = 4;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index codes, taken from the word address.
  typedef enum logic [0:0] {
    REG_PRIME_MODE = 1'b0,
    REG_UNUSED     = 1'b1
  } pcs_reg_t;

  // Pipeline control carried alongside each word.
  typedef struct packed {
    logic valid;
    logic prime;
    logic empty;
  } pcs_ctl_t;

endpackage

FILE: hdl/pcs_lane.sv
// One lane: the set and its inversion rotated to start at a fixed class.
// Registers the rotations and the membership of that class; no package use.
module pcs_lane #(
  parameter int N = 12,
  parameter int K = 0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] mask,
  input  logic [N-1:0] imask,
  output logic         member,
  output logic [N-1:0] rot,
  output logic         imember,
  output logic [N-1:0] irot
);

  logic [N-1:0] rot_next;
  logic [N-1:0] irot_next;

  // Rotate both sets so that class K lands on position 0.
  for (genvar j = 0; j < N; j++) begin : g_rot
    localparam int SRC = (K + j) % N;
    assign rot_next[j]  = mask[SRC];
    assign irot_next[j] = imask[SRC];
  end

  // Lane register, loaded whenever the first stage advances.
  always_ff @(posedge clk) begin
    if (en) begin
      member  <= mask[K];
      rot     <= rot_next;
      imember <= imask[K];
      irot    <= irot_next;
    end
  end

endmodule

FILE: hdl/pcs_merge.sv
// Merging stage: picks the smallest rotation among the member lanes.
// A balanced tree of compares, registered at its root; no package use.
module pcs_merge #(
  parameter int N     = 12,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [N-1:0]     member,
  input  logic [N-1:0]     rot [N],
  output logic [N-1:0]     best_form,
  output logic [IDX_W-1:0] best_start
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
  localparam int LEAVES = 2 ** LEVELS;

  logic [N-1:0]     tree_form;
  logic [IDX_W-1:0] tree_idx;

  // A smaller rotated mask is a smaller interval list read from the span inward.
  // On equal masks the left node, which holds the lower class, is kept.
  always_comb begin
    logic             cv [LEAVES];
    logic [N-1:0]     cf [LEAVES];
    logic [IDX_W-1:0] ci [LEAVES];
    logic             take_b;
    for (int e = 0; e < LEAVES; e++) begin
      if (e < N) begin
        cv[e] = member[e];
        cf[e] = rot[e];
      end else begin
        cv[e] = 1'b0;
        cf[e] = '0;
      end
      ci[e] = IDX_W'(e);
    end
    take_b = 1'b0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      for (int e = 0; e < (LEAVES >> (lv + 1)); e++) begin
        take_b = cv[2*e+1] && (!cv[2*e] || (cf[2*e+1] < cf[2*e]));
        cv[e]  = cv[2*e] || cv[2*e+1];
        cf[e]  = take_b ? cf[2*e+1] : cf[2*e];
        ci[e]  = take_b ? ci[2*e+1] : ci[2*e];
      end
    end
    tree_form = cf[0];
    tree_idx  = ci[0];
  end

  // Root register of the tree.
  always_ff @(posedge clk) begin
    if (en) begin
      best_form  <= tree_form;
      best_start <= tree_idx;
    end
  end

endmodule

FILE: hdl/pitch_class_set_canonical_form.sv
// Pitch-class set canonical form: normal form, or prime form with inversion.
// Uses pcs_pkg, pcs_lane and pcs_merge.
//
// Takes one word per clock and returns one result word per input word. There
// are three register stages. A result passes from the lane registers through the
// compare tree root registers into the output register, and is held there until it
// is taken. One lane per pitch class
// rotates the set and its inversion in the first stage. A compare tree picks the
// smallest rotation of each in the second. In prime mode the output register
// also chooses between the two forms. Throughput is one word per cycle, limited
// only by stalls from downstream. A stalled result first lets the empty stages
// behind it fill, so up to two more input words are taken. After that the input
// is stalled for as long as the output is. The user must see that configuration
// is written via the APB port only while idle; the block does not enforce it.
module pitch_class_set_canonical_form
  import pcs_pkg::*;
#(
  parameter int PITCH_CLASSES = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MASK_W-1:0]     pitch_mask,
  // Output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MASK_W-1:0]     form_mask,
  output logic [START_W-1:0]    start_class,
  output logic                  used_inversion,
  output logic                  empty_set,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int N     = PITCH_CLASSES;
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

  logic     prime_mode;
  pcs_reg_t reg_sel;

  pcs_ctl_t s0;
  pcs_ctl_t s1;
  logic     en0;
  logic     en1;
  logic     en2;

  logic [N+MASK_W-1:0] mask_ext;
  logic [N-1:0]        mask;
  logic [N-1:0]        imask;

  logic [N-1:0] member;
  logic [N-1:0] imember;
  logic [N-1:0] rot  [N];
  logic [N-1:0] irot [N];

  logic [N-1:0]     form_o;
  logic [N-1:0]     form_i;
  logic [IDX_W-1:0] start_o;
  logic [IDX_W-1:0] start_i;

  logic [N-1:0]         diff;
  logic [N-1:0]         low_diff;
  logic                 inv_less;
  logic [N-1:0]         pick_form;
  logic [IDX_W-1:0]     pick_start;
  logic [N+MASK_W-1:0]  form_ext;
  logic [IDX_W+START_W-1:0] start_ext;

  // Configuration register file: a single mode bit at word index zero.
  assign pready  = 1'b1;
  assign reg_sel = pcs_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_PRIME_MODE) begin
      prime_mode <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PRIME_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, prime_mode};
      default:        prdata = '0;
    endcase
  end

  // Stage enables: a stage advances when it is empty or its successor advances.
  assign en2      = !out_valid || !out_stall;
  assign en1      = !s1.valid || en2;
  assign en0      = !s0.valid || en1;
  assign in_stall = !en0;

  // Classes at or above the modulus are dropped; the inversion maps x to -x.
  assign mask_ext = {{N{1'b0}}, pitch_mask};
  assign mask     = mask_ext[N-1:0];

  for (genvar x = 0; x < N; x++) begin : g_inv
    localparam int DST = (N - x) % N;
    assign imask[DST] = mask[x];
  end

  // Lanes, one per candidate starting class.
  for (genvar k = 0; k < N; k++) begin : g_lane
    pcs_lane #(.N(N), .K(k)) u_lane (
      .clk     (clk),
      .en      (en0),
      .mask    (mask),
      .imask   (imask),
      .member  (member[k]),
      .rot     (rot[k]),
      .imember (imember[k]),
      .irot    (irot[k])
    );
  end

  // Stage 0 control travels beside the lane registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (en0) begin
      s0.valid <= in_valid;
    end
    if (en0) begin
      s0.prime <= prime_mode;
      s0.empty <= (mask == '0);
    end
  end

  // Merging trees for the set and for its inversion.
  pcs_merge #(.N(N), .IDX_W(IDX_W)) u_merge_orig (
    .clk        (clk),
    .en         (en1),
    .member     (member),
    .rot        (rot),
    .best_form  (form_o),
    .best_start (start_o)
  );

  pcs_merge #(.N(N), .IDX_W(IDX_W)) u_merge_inv (
    .clk        (clk),
    .en         (en1),
    .member     (imember),
    .rot        (irot),
    .best_form  (form_i),
    .best_start (start_i)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en1) begin
      s1.valid <= s0.valid;
    end
    if (en1) begin
      s1.prime <= s0.prime;
      s1.empty <= s0.empty;
    end
  end

  // Ascending lists compare at the lowest differing class: whichever form
  // holds that class is the smaller one.
  assign diff       = form_o ^ form_i;
  assign low_diff   = diff & (-diff);
  assign inv_less   = s1.prime && (|(low_diff & form_i));
  assign pick_form  = inv_less ? form_i : form_o;
  assign pick_start = inv_less ? start_i : start_o;
  assign form_ext   = {{MASK_W{1'b0}}, pick_form};
  assign start_ext  = {{START_W{1'b0}}, pick_start};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (s1.empty) begin
        form_mask      <= '0;
        start_class    <= '0;
        used_inversion <= 1'b0;
        empty_set      <= 1'b1;
      end else begin
        form_mask      <= form_ext[MASK_W-1:0];
        start_class    <= start_ext[START_W-1:0];
        used_inversion <= inv_less;
        empty_set      <= 1'b0;
      end
    end
  end

  // An empty set never reports a form, a start or an inversion.
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_set |-> form_mask == '0 && start_class == '0 && !used_inversion)
    else $error("empty set word carries a non-zero form");

  // A non-empty form is transposed so that class zero is always present.
  a_form_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_set |-> form_mask[0])
    else $error("canonical form does not start at class zero");

  // The inversion is only chosen when prime mode was in force for that word.
  a_inv_mode: assert property (@(posedge clk) disable iff (rst)
    en2 && s1.valid && !s1.prime |=> !used_inversion)
    else $error("inversion chosen in normal mode");

endmodule
